// ----- rtl/rlew_pkg.sv -----
`default_nettype none

package rlew_pkg;

   // Tag word that opens a run: tag, count, value
   localparam logic [15:0] RLEW_TAG = 16'hABCD;

   // Byte address width; address bit 2 selects between the two config registers
   localparam int unsigned CSR_ADDR_W = 3;

   // Register indexes, taken from paddr[2]
   localparam logic REG_EXPANDED = 1'b0;
   localparam logic REG_STREAM   = 1'b1;

   // Which word of the stream is expected next
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_DATA   = 2'd1,
      PH_COUNT  = 2'd2,
      PH_VALUE  = 2'd3
   } phase_type;

   // Running state of one stream
   typedef struct packed {
      logic [14:0] consumed;   // words consumed, header included
      logic [16:0] produced;   // expanded bytes accounted for
      phase_type   phase;
      logic        decided;    // verdict given, waiting for a new stream
   } track_type;

   // Verdict out of the step logic
   typedef struct packed {
      logic valid;
      logic ok;
   } verdict_type;

endpackage

`default_nettype wire

// ----- rtl/rlew_stream_validator.sv -----
`default_nettype none

// Run-length word stream validator.
// Input channel (req_): one 16-bit stream word per beat in tdata, with tuser
// high on the header word that opens a new stream. Result channel (rsp_):
// one verdict beat per decided stream, tdata bit 0 = 1 for a valid stream.
// Config (csr_): APB-style, expanded_bytes at 0x0 and stream_bytes at 0x4;
// the user must write them only while no stream word is in flight, as the
// block does not enforce it; pready is always high. Throughput: one word
// per cycle while the result register is free or being taken. Each word's
// check is a few 17-bit adds and compares between the input register and
// the result register. The deciding word passes through the input
// register, then the result register, before its verdict is on rsp_.
// Words after a verdict give no beat until the next header word.
// Reset empties both registers, zeroes the config and leaves the block
// waiting for a header word. When the receiver stalls, the verdict holds
// in the result register and the input register still takes one more beat;
// then req_tready drops until the verdict is taken.
module rlew_stream_validator
   import rlew_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // stream words
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [15:0] word
   input  wire logic                  req_tuser,   // [0] first
   // verdicts
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [0] ok, [7:1] zero
   // config
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [15:0] exp_bytes_ff;
   logic [15:0] strm_bytes_ff;

   logic        in_valid_ff;
   logic [15:0] in_word_ff;
   logic        in_first_ff;

   logic        rsp_valid_ff;
   logic        rsp_ok_ff;
   logic        rsp_valid_in;

   track_type   track_ff;
   track_type   track_in;
   verdict_type verdict;

   logic        step_go;
   logic        csr_wr;

   // Config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_bytes_ff  <= '0;
         strm_bytes_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_EXPANDED) begin
            exp_bytes_ff <= csr_pwdata[15:0];
         end else begin
            strm_bytes_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_STREAM) begin
         csr_prdata = {16'd0, strm_bytes_ff};
      end else begin
         csr_prdata = {16'd0, exp_bytes_ff};
      end
   end

   // Word in the input register moves on when the result slot is free or being taken
   assign step_go    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         in_word_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   // Stream checking
   rlew_step u_step (
      .word           (in_word_ff),
      .first          (in_first_ff),
      .expanded_bytes (exp_bytes_ff),
      .stream_bytes   (strm_bytes_ff),
      .cur            (track_ff),
      .nxt            (track_in),
      .verdict        (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff.consumed <= '0;
         track_ff.produced <= '0;
         track_ff.phase    <= PH_HEADER;
         track_ff.decided  <= 1'b1;
      end else if (step_go) begin
         track_ff <= track_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (step_go) begin
         rsp_valid_in = verdict.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go & verdict.valid) begin
         rsp_ok_ff <= verdict.ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff};

endmodule

`default_nettype wire

// ----- rtl/rlew_step.sv -----
`default_nettype none

// Next-state and verdict logic for one stream word
module rlew_step
   import rlew_pkg::*;
(
   input  wire logic [15:0] word,
   input  wire logic        first,
   input  wire logic [15:0] expanded_bytes,
   input  wire logic [15:0] stream_bytes,
   input  wire track_type   cur,
   output track_type        nxt,
   output verdict_type      verdict
);

   logic [16:0] exp_ext;
   logic [16:0] strm_ext;
   logic [16:0] pos_cur;
   logic [14:0] cons_inc;
   logic [16:0] run;
   logic [16:0] owed;
   logic        cfg_bad;

   assign exp_ext  = {1'b0, expanded_bytes};
   assign strm_ext = {1'b0, stream_bytes};
   assign pos_cur  = {1'b0, cur.consumed, 1'b0};
   assign cons_inc = cur.consumed + 15'd1;
   assign run      = {word, 1'b0};
   assign owed     = (exp_ext > cur.produced) ? (exp_ext - cur.produced) : 17'd0;
   assign cfg_bad  = (stream_bytes < 16'd2) | stream_bytes[0] | expanded_bytes[0];

   // Check after the read position moved: total reached, or stream exhausted
   function automatic void advance_check(
      input  logic [14:0] cons_n,
      input  logic [16:0] prod_n,
      input  logic [16:0] expd,
      input  logic [16:0] strm,
      output phase_type   ph,
      output logic        vld,
      output logic        okv,
      output logic        dec
   );
      logic [16:0] pos_n;
      pos_n = {1'b0, cons_n, 1'b0};
      ph    = PH_HEADER;
      vld   = 1'b0;
      okv   = 1'b0;
      dec   = 1'b0;
      if (prod_n >= expd) begin
         vld = 1'b1;
         okv = (prod_n == expd) && (pos_n == strm);
         dec = 1'b1;
      end else if ((pos_n + 17'd2) > strm) begin
         vld = 1'b1;
         dec = 1'b1;
      end else begin
         ph = PH_DATA;
      end
   endfunction

   always_comb begin
      nxt     = cur;
      verdict = '{valid: 1'b0, ok: 1'b0};

      if (first) begin
         // New stream: header word
         nxt.consumed = 15'd0;
         nxt.produced = 17'd0;
         if (cfg_bad || (word != expanded_bytes)) begin
            verdict.valid = 1'b1;
            nxt.decided   = 1'b1;
            nxt.phase     = PH_HEADER;
         end else begin
            nxt.consumed = 15'd1;
            advance_check(15'd1, 17'd0, exp_ext, strm_ext,
                          nxt.phase, verdict.valid, verdict.ok, nxt.decided);
         end
      end else if (!cur.decided) begin
         case (cur.phase)
            PH_DATA: begin
               if (word == RLEW_TAG) begin
                  if ((pos_cur + 17'd6) > strm_ext) begin
                     verdict.valid = 1'b1;
                     nxt.decided   = 1'b1;
                     nxt.phase     = PH_HEADER;
                  end else begin
                     nxt.consumed = cons_inc;
                     nxt.phase    = PH_COUNT;
                  end
               end else begin
                  nxt.consumed = cons_inc;
                  nxt.produced = cur.produced + 17'd2;
                  advance_check(cons_inc, cur.produced + 17'd2, exp_ext, strm_ext,
                                nxt.phase, verdict.valid, verdict.ok, nxt.decided);
               end
            end
            PH_COUNT: begin
               if (run > owed) begin
                  verdict.valid = 1'b1;
                  nxt.decided   = 1'b1;
                  nxt.phase     = PH_HEADER;
               end else begin
                  nxt.produced = cur.produced + run;
                  nxt.consumed = cons_inc;
                  nxt.phase    = PH_VALUE;
               end
            end
            PH_VALUE: begin
               // value word itself is not examined
               nxt.consumed = cons_inc;
               advance_check(cons_inc, cur.produced, exp_ext, strm_ext,
                             nxt.phase, verdict.valid, verdict.ok, nxt.decided);
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb_rlew_stream_validator.sv -----
module tb_rlew_stream_validator
   import rlew_pkg::*;
();

   localparam int ITEMS = 450;
   localparam int HOLD_CYCLES = 60;
   localparam int GAP_PCT = 35;
   localparam int PRESSURE_PHASE = 3;
   localparam int QUIET_LAST = 5;

   // how a directed row's verdict is known
   typedef enum logic [1:0] {
      OUT_PREDICTED = 2'd0,
      OUT_NONE      = 2'd1,
      OUT_OK        = 2'd2,
      OUT_BAD       = 2'd3
   } outcome_type;

   localparam logic ROW_WORD = 1'b0;
   localparam logic ROW_CSR  = 1'b1;

   // one directed step: a stream word, or a register write (reg_sel unused for words)
   typedef struct packed {
      logic        kind;
      logic        reg_sel;
      logic [15:0] value;
      logic        first;
      outcome_type want;
   } drill_row_type;

   localparam drill_row_type DRILL [35] = '{
      // ignored after reset, then bad config: stream too short, odd, minimal
      '{ROW_WORD, REG_EXPANDED, 16'h1234, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'h0000, 1'b1, OUT_BAD},
      '{ROW_CSR,  REG_STREAM,   16'h0003, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'h0000, 1'b1, OUT_BAD},
      '{ROW_CSR,  REG_STREAM,   16'h0002, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'h0000, 1'b1, OUT_OK},
      '{ROW_CSR,  REG_EXPANDED, 16'h0001, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'h0001, 1'b1, OUT_BAD},
      '{ROW_CSR,  REG_EXPANDED, 16'h0008, 1'b0, OUT_NONE},
      '{ROW_CSR,  REG_STREAM,   16'h000A, 1'b0, OUT_NONE},
      // header mismatch
      '{ROW_WORD, REG_EXPANDED, 16'hFFFF, 1'b1, OUT_BAD},
      // run longer than what is owed, then a word after the verdict
      '{ROW_WORD, REG_EXPANDED, 16'h0008, 1'b1, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, RLEW_TAG, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'hFFFF, 1'b0, OUT_BAD},
      '{ROW_WORD, REG_EXPANDED, RLEW_TAG, 1'b0, OUT_NONE},
      // abandoned stream, restart, then a clean stream with one run
      '{ROW_WORD, REG_EXPANDED, 16'h0008, 1'b1, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h1111, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h0008, 1'b1, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h0000, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, RLEW_TAG, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h0003, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'hFFFF, 1'b0, OUT_PREDICTED},
      // stream too short for a run, then for another data word
      '{ROW_CSR,  REG_STREAM,   16'h0004, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'h0008, 1'b1, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, RLEW_TAG, 1'b0, OUT_BAD},
      '{ROW_WORD, REG_EXPANDED, 16'h0008, 1'b1, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h7FFF, 1'b0, OUT_BAD},
      // largest sizes: total reached long before the stream ends
      '{ROW_CSR,  REG_EXPANDED, 16'hFFFE, 1'b0, OUT_NONE},
      '{ROW_CSR,  REG_STREAM,   16'hFFFE, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'hFFFE, 1'b1, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, RLEW_TAG, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h7FFF, 1'b0, OUT_PREDICTED},
      '{ROW_WORD, REG_EXPANDED, 16'h0000, 1'b0, OUT_PREDICTED},
      '{ROW_CSR,  REG_STREAM,   16'hFFFF, 1'b0, OUT_NONE},
      '{ROW_WORD, REG_EXPANDED, 16'hFFFE, 1'b1, OUT_BAD}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;   // [15:0] word
   logic                  req_tuser;   // [0] first
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [0] ok, [7:1] zero
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shared stimulus controls
   logic gaps_on;
   logic hold_ask;

   // verdicts still owed by the block, oldest first
   bit   verdicts_due [$];
   int   failures;
   int   words_checked;

   // predictor copy of the registers and stream state
   logic [15:0] cfg_expanded;
   logic [15:0] cfg_stream;
   logic [14:0] trk_words;
   logic [16:0] trk_bytes;
   phase_type   trk_phase;
   logic        trk_done;

   // layout of the stream under test: -1 is a literal word, else a run count
   int run_plan [$];

   rlew_stream_validator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL rlew_stream_validator");
      $finish;
   end

   // decide now if the total is reached or no further word fits
   function automatic void settle_total(output bit due, output bit ok);
      int unsigned pos;
      pos = 32'(trk_words) * 2;
      due = 1'b1;
      ok  = 1'b0;
      if (32'(trk_bytes) >= 32'(cfg_expanded)) begin
         ok = (32'(trk_bytes) == 32'(cfg_expanded)) && (pos == 32'(cfg_stream));
      end else if (pos + 2 <= 32'(cfg_stream)) begin
         due = 1'b0;
         trk_phase = PH_DATA;
      end
   endfunction

   // account one accepted word; returns 1 when it yields a verdict
   function automatic bit rlew_account_word(input logic [15:0] w, input logic f,
                                            output bit ok);
      int unsigned pos;
      int unsigned run;
      int unsigned owed;
      bit          due;
      due = 1'b0;
      ok  = 1'b0;
      if (f) begin
         trk_words = '0;
         trk_bytes = '0;
         trk_done  = 1'b0;
         if (cfg_stream < 16'd2 || cfg_stream[0] || cfg_expanded[0] || w != cfg_expanded) begin
            due = 1'b1;
         end else begin
            trk_words = 15'd1;
            settle_total(due, ok);
         end
      end else if (!trk_done) begin
         pos = 32'(trk_words) * 2;
         case (trk_phase)
            PH_DATA: begin
               if (w == RLEW_TAG) begin
                  if (pos + 6 > 32'(cfg_stream)) begin
                     due = 1'b1;
                  end else begin
                     trk_words = trk_words + 15'd1;
                     trk_phase = PH_COUNT;
                  end
               end else begin
                  trk_words = trk_words + 15'd1;
                  trk_bytes = trk_bytes + 17'd2;
                  settle_total(due, ok);
               end
            end
            PH_COUNT: begin
               run  = 32'(w) * 2;
               owed = (32'(cfg_expanded) > 32'(trk_bytes)) ?
                      32'(cfg_expanded) - 32'(trk_bytes) : 0;
               if (run > owed) begin
                  due = 1'b1;
               end else begin
                  trk_bytes = trk_bytes + 17'(run);
                  trk_words = trk_words + 15'd1;
                  trk_phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               trk_words = trk_words + 15'd1;
               settle_total(due, ok);
            end
            default: ;
         endcase
      end
      if (due) begin
         trk_done  = 1'b1;
         trk_phase = PH_HEADER;
      end
      return due;
   endfunction

   // offer one word, wait for its beat, then book its verdict if any
   task automatic push_word(input logic [15:0] w, input logic f, input outcome_type want);
      bit due;
      bit ok;
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_checked++;
      due = rlew_account_word(w, f, ok);
      case (want)
         OUT_PREDICTED: if (due) verdicts_due.push_back(ok);
         OUT_OK:        verdicts_due.push_back(1'b1);
         OUT_BAD:       verdicts_due.push_back(1'b0);
         default: ;
      endcase
   endtask

   // let every owed verdict drain, plus the pipeline depth for silent words
   task automatic settle_pipe();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access until pready
   task automatic csr_write(input logic sel, input logic [15:0] value);
      settle_pipe();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (sel == REG_EXPANDED) cfg_expanded = value;
      else cfg_stream = value;
   endtask

   // one stream following run_plan, with random content and an occasional defect
   task automatic play_stream();
      logic [15:0] words [$];
      logic [15:0] w;
      int          fate;
      int          cut;
      words.push_back(cfg_expanded);
      foreach (run_plan[i]) begin
         if (run_plan[i] < 0) begin
            w = 16'($urandom);
            if (w == RLEW_TAG) w = w ^ 16'h0001;
            words.push_back(w);
         end else begin
            words.push_back(RLEW_TAG);
            words.push_back(16'(run_plan[i]));
            words.push_back(16'($urandom));
         end
      end
      fate = $urandom_range(99);
      if (fate < 10) begin
         words[$urandom_range(words.size() - 1)] = 16'($urandom);
      end else if (fate < 16) begin
         words[$urandom_range(words.size() - 1)] = RLEW_TAG;
      end else if (fate < 24 && words.size() > 1) begin
         // truncated: unless already decided, the next header abandons it without a verdict
         cut = $urandom_range(1, words.size() - 1);
         while (words.size() > cut) void'(words.pop_back());
      end else if (fate < 30) begin
         words.push_back(16'($urandom));
      end
      foreach (words[i]) push_word(words[i], i == 0, OUT_PREDICTED);
      // trailing junk after the stream's words
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) push_word(16'($urandom), 1'b0, OUT_PREDICTED);
      end
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin : verdict_taker
      int  hold_left;
      bit  hold_spent;
      hold_left  = 0;
      hold_spent = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_spent) begin
            hold_left  = HOLD_CYCLES;
            hold_spent = 1'b1;
         end
         rsp_tready <= (hold_left == 0) && (!gaps_on || $urandom_range(99) >= GAP_PCT);
         if (hold_left > 0) hold_left--;
      end
   end

   // compare each verdict beat against the oldest owed verdict
   always @(posedge clock) begin : verdict_check
      bit want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $error("unexpected verdict beat, ok=%0b", rsp_tdata[0]);
            failures++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("ok: expected %0b, actual %0b", want, rsp_tdata[0]);
               failures++;
            end
         end
      end
   end

   initial begin : stimulus
      int phase_no;
      int exp_total;
      int stream_len;
      int fate;
      int tail;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      gaps_on     <= 1'b1;
      hold_ask    <= 1'b0;
      failures      = 0;
      words_checked = 0;
      cfg_expanded  = '0;
      cfg_stream    = '0;
      trk_words     = '0;
      trk_bytes     = '0;
      trk_phase     = PH_HEADER;
      trk_done      = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < $size(DRILL); i++) begin
         if (DRILL[i].kind == ROW_CSR) csr_write(DRILL[i].reg_sel, DRILL[i].value);
         else push_word(DRILL[i].value, DRILL[i].first, DRILL[i].want);
      end

      // random phases: each picks a stream layout, sizes the registers to it,
      // then sends several streams of that layout; the quiet phases always run
      phase_no = 0;
      while (words_checked < ITEMS || phase_no <= QUIET_LAST) begin
         run_plan.delete();
         case (phase_no)
            1: run_plan.push_back(32'h7FFF);
            PRESSURE_PHASE: ;   // empty expansion: every header gives a verdict
            default: begin
               repeat ($urandom_range(0, 6)) begin
                  run_plan.push_back(($urandom_range(3) == 0) ? int'($urandom_range(0, 8)) : -1);
               end
            end
         endcase
         exp_total  = 0;
         stream_len = 2;
         foreach (run_plan[i]) begin
            if (run_plan[i] < 0) begin
               exp_total  += 2;
               stream_len += 2;
            end else begin
               exp_total  += 2 * run_plan[i];
               stream_len += 6;
            end
         end
         // some phases get registers that no stream can satisfy
         fate = $urandom_range(99);
         if (phase_no > QUIET_LAST) begin
            if (fate < 5) exp_total = exp_total | 1;
            else if (fate < 10) stream_len = stream_len | 1;
            else if (fate < 15) stream_len = stream_len + 2;
            else if (fate < 19) stream_len = 32'hFFFE;
            else if (fate < 23) exp_total = exp_total + 2;
         end
         gaps_on <= !(phase_no >= PRESSURE_PHASE && phase_no <= QUIET_LAST);
         csr_write(REG_EXPANDED, 16'(exp_total));
         csr_write(REG_STREAM, 16'(stream_len));
         if (phase_no == PRESSURE_PHASE) hold_ask <= 1'b1;
         repeat ((phase_no == PRESSURE_PHASE) ? 12 : $urandom_range(3, 7)) play_stream();
         phase_no++;
      end

      // drain, with a bound
      req_tvalid <= 1'b0;
      tail = 0;
      while (verdicts_due.size() != 0 && tail < 2000) begin
         @(posedge clock);
         tail++;
      end
      repeat (8) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         $error("%0d verdicts never arrived", verdicts_due.size());
         failures++;
      end
      if (failures == 0) $display("PASS rlew_stream_validator");
      else $display("FAIL rlew_stream_validator");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rlew_pkg.sv
rtl/rlew_step.sv
rtl/rlew_stream_validator.sv
dv/tb_rlew_stream_validator.sv
